@@ rtl/core/plate_character_orderer_macros.svh @@
// assertion macros shared by the plate character orderer rtl
`ifndef PLATE_CHARACTER_ORDERER_MACROS_SVH
`define PLATE_CHARACTER_ORDERER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define PCO_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pco assertion failed");
// expression must never be true out of reset
`define PCO_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("pco forbidden condition seen");
`else
`define PCO_ASSERT(lbl, clk, rst_n, prop)
`define PCO_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/core/pco_pkg.sv @@
// shared constants and types of the plate character orderer
package pco_pkg;
	localparam int MAX_CHARS  = 10;
	localparam int COORD_BITS = 12;
	localparam int CLASS_BITS = 6;
	localparam int CONF_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_CHARS);
	localparam int CNT_W      = $clog2(MAX_CHARS + 1);
	localparam int GEO_W      = 4 * COORD_BITS;
	localparam int ATT_W      = CLASS_BITS + CONF_BITS;
	localparam int SUM_W      = COORD_BITS + CNT_W;
	localparam int SQ_W       = 2 * COORD_BITS + CNT_W;
	localparam int PROD_W     = 2 * COORD_BITS + 2 * CNT_W;
	localparam int MUL_W      = SQ_W + SUM_W;

	typedef struct packed {
		logic             append;
		logic             replace;
		logic             clear;
		logic [IDX_W-1:0] pos;
	} store_cmd_t;

	typedef struct packed {
		logic                  line;
		logic [COORD_BITS-1:0] x;
		logic [IDX_W-1:0]      idx;
		logic [CONF_BITS-1:0]  conf;
	} list_entry_t;
endpackage

@@ rtl/core/plate_character_orderer.sv @@
// plate character orderer top level: sequencer, shared multiplier and ordering list
//
// usage
// - input channel (in_valid / in_stall) carries one character box per item; last_box
//   marks the final box of a plate
// - output channel (out_valid / out_stall) carries the ordered boxes of a plate, top
//   line first, sorted left to right, close neighbors merged; last_char on the final one
// - a non-final box while fewer than MAX_CHARS are kept is appended; the sequencer stays idle
// - with the store full, the store is read one entry per cycle while the minimum
//   probability is searched, then drop and shift, unless the new box is lower
// - a final box then runs the sums, the multiply and compare steps, line assignment,
//   bubble passes and merging, all through one shared multiplier, one store read port
//   and one list read port; then one item per cycle is emitted while out_stall is
//   low
// - in_stall is high whenever the sequencer is busy
// - the output register holds an item while out_stall is high; the sequencer waits
// - reset clears the kept count and all control; stored boxes need no clearing
module plate_character_orderer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pco_pkg::COORD_BITS-1:0]       box_x,
	input  logic [pco_pkg::COORD_BITS-1:0]       box_y,
	input  logic [pco_pkg::COORD_BITS-1:0]       box_w,
	input  logic [pco_pkg::COORD_BITS-1:0]       box_h,
	input  logic [pco_pkg::CLASS_BITS-1:0]       char_class,
	input  logic [pco_pkg::CONF_BITS-1:0]        confidence,
	input  logic                                 last_box,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pco_pkg::COORD_BITS-1:0]       out_x,
	output logic [pco_pkg::COORD_BITS-1:0]       out_y,
	output logic [pco_pkg::COORD_BITS-1:0]       out_w,
	output logic [pco_pkg::COORD_BITS-1:0]       out_h,
	output logic [pco_pkg::CLASS_BITS-1:0]       out_class,
	output logic [pco_pkg::CONF_BITS-1:0]        out_confidence,
	output logic                                 second_line,
	output logic                                 last_char
);
`include "plate_character_orderer_macros.svh"

	localparam int C = pco_pkg::COORD_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_SUM, ST_PNSY2, ST_PSY, ST_PSH, ST_CMP,
		ST_CLASS, ST_SORT, ST_MERGE, ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [pco_pkg::CNT_W-1:0]      ptr_q, pass_q, wr_q, total_q;
	logic [pco_pkg::GEO_W-1:0]      geo_in_q;
	logic [pco_pkg::ATT_W-1:0]      att_in_q;
	logic                           last_in_q;
	logic [pco_pkg::CONF_BITS-1:0]  min_q;
	logic [pco_pkg::IDX_W-1:0]      pos_q;
	logic [pco_pkg::SUM_W-1:0]      sy_q, sw_q, sh_q;
	logic [pco_pkg::SQ_W-1:0]       sy2_q;
	logic [pco_pkg::PROD_W-1:0]     pa_q, pb_q, pc_q;
	logic                           two_q;
	pco_pkg::list_entry_t           list_q [pco_pkg::MAX_CHARS];
	pco_pkg::list_entry_t           carry_q;

	logic                           out_valid_q, last_char_q, line_q;
	logic [pco_pkg::GEO_W-1:0]      out_geo_q;
	logic [pco_pkg::ATT_W-1:0]      out_att_q;

	// store port
	pco_pkg::store_cmd_t            cmd;
	logic [pco_pkg::GEO_W-1:0]      wr_geo, rd_geo;
	logic [pco_pkg::ATT_W-1:0]      wr_att, rd_att;
	logic [pco_pkg::IDX_W-1:0]      rd_idx, ptr_idx;
	logic [pco_pkg::CNT_W-1:0]      n;

	// shared multiplier
	logic [pco_pkg::SQ_W-1:0]       mul_a;
	logic [pco_pkg::SUM_W-1:0]      mul_b;
	logic [pco_pkg::MUL_W-1:0]      mul_p;

	logic                           in_acc, load, emit_last, seq_done, mrg_hit;
	pco_pkg::list_entry_t           e, wr_ent;
	logic                           lwr_en;
	logic [pco_pkg::IDX_W-1:0]      lwr_idx;
	logic [C-1:0]                   y, dx;
	logic [pco_pkg::SUM_W-1:0]      n_ext;
	logic [pco_pkg::PROD_W+1:0]     spread;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign ptr_idx  = ptr_q[pco_pkg::IDX_W-1:0];
	assign e        = list_q[ptr_idx];
	assign y        = rd_geo[2*C-1:C];
	assign n_ext    = {{(pco_pkg::SUM_W-pco_pkg::CNT_W){1'b0}}, n};
	assign dx       = e.x - carry_q.x;
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = (ptr_q == total_q - 1'b1);
	assign seq_done = (ptr_q == n);
	// neighbors on the same line closer than half the mean width merge
	assign mrg_hit  = (e.line == carry_q.line) &&
		({mul_p[pco_pkg::SUM_W-1:0], 1'b0} < {1'b0, sw_q});
	// spread test: 4*(n*sum(y^2) - sum(y)^2)
	assign spread   = {pa_q - pb_q, 2'b00};

	assign wr_geo = in_acc ? {box_h, box_w, box_y, box_x} : geo_in_q;
	assign wr_att = in_acc ? {confidence, char_class} : att_in_q;

	always_comb begin
		cmd         = '0;
		cmd.pos     = pos_q;
		cmd.append  = in_acc && (n < pco_pkg::CNT_W'(pco_pkg::MAX_CHARS));
		cmd.replace = (state_q == ST_DECIDE) &&
			!(att_in_q[pco_pkg::ATT_W-1:pco_pkg::CLASS_BITS] < min_q);
		cmd.clear   = load && emit_last;
	end

	assign rd_idx = (state_q == ST_EMIT) ? e.idx : ptr_idx;

	pco_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wr_geo (wr_geo),
		.wr_att (wr_att),
		.rd_idx (rd_idx),
		.rd_geo (rd_geo),
		.rd_att (rd_att),
		.count  (n)
	);

	// operand select for the one multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SUM: begin
				mul_a = pco_pkg::SQ_W'(y);
				mul_b = pco_pkg::SUM_W'(y);
			end
			ST_PNSY2: begin
				mul_a = sy2_q;
				mul_b = n_ext;
			end
			ST_PSY: begin
				mul_a = pco_pkg::SQ_W'(sy_q);
				mul_b = sy_q;
			end
			ST_PSH: begin
				mul_a = pco_pkg::SQ_W'(sh_q);
				mul_b = sh_q;
			end
			ST_CLASS: begin
				mul_a = pco_pkg::SQ_W'(y);
				mul_b = n_ext;
			end
			ST_MERGE: begin
				mul_a = pco_pkg::SQ_W'(dx);
				mul_b = n_ext;
			end
			default: ;
		endcase
	end
	assign mul_p = pco_pkg::MUL_W'(mul_a) * pco_pkg::MUL_W'(mul_b);

	// list write port: one address per cycle
	always_comb begin
		lwr_en  = 1'b0;
		lwr_idx = ptr_idx;
		wr_ent  = carry_q;
		case (state_q)
			ST_CLASS: begin
				lwr_en       = 1'b1;
				wr_ent.line  = two_q && !(mul_p[pco_pkg::SUM_W-1:0] < sy_q);
				wr_ent.x     = rd_geo[C-1:0];
				wr_ent.idx   = ptr_idx;
				wr_ent.conf  = rd_att[pco_pkg::ATT_W-1:pco_pkg::CLASS_BITS];
			end
			ST_SORT: begin
				if (seq_done) begin
					lwr_en  = 1'b1;
					lwr_idx = pco_pkg::IDX_W'(n - 1'b1);
				end else if (ptr_q != '0) begin
					lwr_en  = 1'b1;
					lwr_idx = pco_pkg::IDX_W'(ptr_q - 1'b1);
					// stable: only a strictly larger key moves right
					wr_ent  = ({carry_q.line, carry_q.x} > {e.line, e.x}) ? e : carry_q;
				end
			end
			ST_MERGE: begin
				lwr_idx = wr_q[pco_pkg::IDX_W-1:0];
				lwr_en  = seq_done || ((ptr_q != '0) && !mrg_hit);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lwr_en) begin
			list_q[lwr_idx] <= wr_ent;
		end
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			pass_q      <= '0;
			wr_q        <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					if (in_acc) begin
						if (n < pco_pkg::CNT_W'(pco_pkg::MAX_CHARS)) begin
							if (last_box) begin
								state_q <= ST_SUM;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == pco_pkg::CNT_W'(pco_pkg::MAX_CHARS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					ptr_q   <= '0;
					state_q <= last_in_q ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == n - 1'b1) begin
						state_q <= ST_PNSY2;
					end
				end
				ST_PNSY2: state_q <= ST_PSY;
				ST_PSY:   state_q <= ST_PSH;
				ST_PSH:   state_q <= ST_CMP;
				ST_CMP: begin
					ptr_q   <= '0;
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (ptr_q == n - 1'b1) begin
						ptr_q   <= '0;
						pass_q  <= '0;
						state_q <= ST_SORT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_SORT: begin
					if (seq_done) begin
						ptr_q  <= '0;
						pass_q <= pass_q + 1'b1;
						if (pass_q == n - 1'b1) begin
							state_q <= ST_MERGE;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_MERGE: begin
					if (seq_done) begin
						total_q <= wr_q + 1'b1;
						ptr_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						if (ptr_q == '0) begin
							wr_q <= '0;
						end else if (!mrg_hit) begin
							wr_q <= wr_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						ptr_q <= ptr_q + 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			geo_in_q  <= wr_geo;
			att_in_q  <= wr_att;
			last_in_q <= last_box;
			sy_q  <= '0;
			sy2_q <= '0;
			sw_q  <= '0;
			sh_q  <= '0;
		end
		case (state_q)
			ST_SCAN: begin
				// earliest minimum wins
				if (ptr_q == '0 ||
					rd_att[pco_pkg::ATT_W-1:pco_pkg::CLASS_BITS] < min_q) begin
					min_q <= rd_att[pco_pkg::ATT_W-1:pco_pkg::CLASS_BITS];
					pos_q <= ptr_idx;
				end
			end
			ST_SUM: begin
				sy_q  <= sy_q + pco_pkg::SUM_W'(y);
				sy2_q <= sy2_q + pco_pkg::SQ_W'(mul_p[2*C-1:0]);
				sw_q  <= sw_q + pco_pkg::SUM_W'(rd_geo[3*C-1:2*C]);
				sh_q  <= sh_q + pco_pkg::SUM_W'(rd_geo[4*C-1:3*C]);
			end
			ST_PNSY2: pa_q <= mul_p[pco_pkg::PROD_W-1:0];
			ST_PSY:   pb_q <= mul_p[pco_pkg::PROD_W-1:0];
			ST_PSH:   pc_q <= mul_p[pco_pkg::PROD_W-1:0];
			ST_CMP:   two_q <= spread > {2'b00, pc_q};
			ST_SORT: begin
				if (ptr_q == '0) begin
					carry_q <= e;
				end else if (!seq_done &&
					!({carry_q.line, carry_q.x} > {e.line, e.x})) begin
					carry_q <= e;
				end
			end
			ST_MERGE: begin
				if (ptr_q == '0) begin
					carry_q <= e;
				end else if (!seq_done) begin
					if (!mrg_hit || !(e.conf < carry_q.conf)) begin
						carry_q <= e;
					end
				end
			end
			default: ;
		endcase
		if (load) begin
			out_geo_q   <= rd_geo;
			out_att_q   <= rd_att;
			line_q      <= e.line;
			last_char_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_x          = out_geo_q[C-1:0];
	assign out_y          = out_geo_q[2*C-1:C];
	assign out_w          = out_geo_q[3*C-1:2*C];
	assign out_h          = out_geo_q[4*C-1:3*C];
	assign out_class      = out_att_q[pco_pkg::CLASS_BITS-1:0];
	assign out_confidence = out_att_q[pco_pkg::ATT_W-1:pco_pkg::CLASS_BITS];
	assign second_line    = line_q;
	assign last_char      = last_char_q;

	`PCO_NEVER(a_cnt_range, clk, arst_n, n > pco_pkg::CNT_W'(pco_pkg::MAX_CHARS))
	`PCO_ASSERT(a_clear_after_run, clk, arst_n, (load && emit_last) |=> (n == '0))
	`PCO_ASSERT(a_total_fits, clk, arst_n, (state_q == ST_EMIT) |-> (total_q != '0 && total_q <= n))
	`PCO_ASSERT(a_emit_in_order, clk, arst_n, (load && !emit_last) |=> (state_q == ST_EMIT))
endmodule

@@ rtl/core/pco_store.sv @@
// kept box store: append, drop-and-shift replace, single read port
module pco_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pco_pkg::store_cmd_t       cmd,
	input  logic [pco_pkg::GEO_W-1:0] wr_geo,
	input  logic [pco_pkg::ATT_W-1:0] wr_att,
	input  logic [pco_pkg::IDX_W-1:0] rd_idx,
	output logic [pco_pkg::GEO_W-1:0] rd_geo,
	output logic [pco_pkg::ATT_W-1:0] rd_att,
	output logic [pco_pkg::CNT_W-1:0] count
);
	logic [pco_pkg::GEO_W-1:0] geo_q [pco_pkg::MAX_CHARS];
	logic [pco_pkg::ATT_W-1:0] att_q [pco_pkg::MAX_CHARS];
	logic [pco_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else if (cmd.append) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			geo_q[cnt_q[pco_pkg::IDX_W-1:0]] <= wr_geo;
			att_q[cnt_q[pco_pkg::IDX_W-1:0]] <= wr_att;
		end else if (cmd.replace) begin
			for (int i = 0; i < pco_pkg::MAX_CHARS - 1; i++) begin
				if (i >= int'(cmd.pos)) begin
					geo_q[i] <= geo_q[i+1];
					att_q[i] <= att_q[i+1];
				end
			end
			geo_q[pco_pkg::MAX_CHARS-1] <= wr_geo;
			att_q[pco_pkg::MAX_CHARS-1] <= wr_att;
		end
	end

	assign rd_geo = geo_q[rd_idx];
	assign rd_att = att_q[rd_idx];
	assign count  = cnt_q;
endmodule

@@ dv/plate_character_orderer_tb.sv @@
// testbench for the plate character orderer: random plates checked against a predictor
`timescale 1ns / 1ps

module plate_character_orderer_tb;

	typedef struct {
		logic [pco_pkg::COORD_BITS-1:0] x, y, w, h;
		logic [pco_pkg::CLASS_BITS-1:0] cls;
		logic [pco_pkg::CONF_BITS-1:0]  conf;
	} char_box_t;

	typedef struct {
		char_box_t b;
		logic      line;
		logic      last;
	} ordered_char_t;

	// predictor of the ordered run plus the queue of expected characters
	class plate_scoreboard;
		char_box_t     kept[$];
		ordered_char_t pending[$];
		int            errors;
		int            checked;

		function automatic void order_line(ref int ln[$], input longint n, input longint sw);
			int t, j, drop;
			longint dx;
			for (int i = 1; i < ln.size(); i++) begin
				t = ln[i];
				j = i;
				while (j > 0 && kept[ln[j-1]].x > kept[t].x) begin
					ln[j] = ln[j-1];
					j--;
				end
				ln[j] = t;
			end
			j = 0;
			while (ln.size() >= 2 && j < ln.size() - 1) begin
				dx = longint'(kept[ln[j+1]].x) - longint'(kept[ln[j]].x);
				if (2 * n * dx < sw) begin
					// lower probability is dropped, left one on a tie
					drop = (kept[ln[j+1]].conf < kept[ln[j]].conf) ? j + 1 : j;
					ln.delete(drop);
				end else begin
					j++;
				end
			end
		endfunction

		function automatic void note_box(char_box_t b, logic last);
			int pos, total, k;
			longint n, sy, sy2, sw, sh, yy;
			logic two;
			int ln0[$], ln1[$];
			ordered_char_t o;
			if (kept.size() < pco_pkg::MAX_CHARS) begin
				kept.insert(kept.size(), b);
			end else begin
				pos = 0;
				for (int i = 1; i < pco_pkg::MAX_CHARS; i++)
					if (kept[i].conf < kept[pos].conf) pos = i;
				if (b.conf >= kept[pos].conf) begin
					kept.delete(pos);
					kept.insert(kept.size(), b);
				end
			end
			if (!last) return;
			n = longint'(kept.size());
			if (n < 2) begin
				o.b = kept[0]; o.line = 1'b0; o.last = 1'b1;
				pending.insert(pending.size(), o);
				kept.delete();
				return;
			end
			sy = 0; sy2 = 0; sw = 0; sh = 0;
			foreach (kept[i]) begin
				yy = longint'(kept[i].y);
				sy += yy; sy2 += yy * yy;
				sw += longint'(kept[i].w); sh += longint'(kept[i].h);
			end
			two = 4 * (n * sy2 - sy * sy) > sh * sh;
			foreach (kept[i]) begin
				yy = longint'(kept[i].y);
				if (two && !(n * yy < sy)) ln1.insert(ln1.size(), i);
				else ln0.insert(ln0.size(), i);
			end
			order_line(ln0, n, sw);
			order_line(ln1, n, sw);
			total = ln0.size() + ln1.size();
			k = 0;
			foreach (ln0[i]) begin
				o.b = kept[ln0[i]]; o.line = 1'b0; k++; o.last = (k == total);
				pending.insert(pending.size(), o);
			end
			foreach (ln1[i]) begin
				o.b = kept[ln1[i]]; o.line = 1'b1; k++; o.last = (k == total);
				pending.insert(pending.size(), o);
			end
			kept.delete();
		endfunction

		function automatic void check_char(ordered_char_t got);
			ordered_char_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected character x=%0d y=%0d", $time, got.b.x, got.b.y);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.b.x !== got.b.x || e.b.y !== got.b.y || e.b.w !== got.b.w ||
			    e.b.h !== got.b.h || e.b.cls !== got.b.cls || e.b.conf !== got.b.conf ||
			    e.line !== got.line || e.last !== got.last) begin
				$display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d c=%0d p=%0d l=%0b e=%0b",
					$time, e.b.x, e.b.y, e.b.w, e.b.h, e.b.cls, e.b.conf, e.line, e.last);
				$display("%0t:          actual x=%0d y=%0d w=%0d h=%0d c=%0d p=%0d l=%0b e=%0b",
					$time, got.b.x, got.b.y, got.b.w, got.b.h, got.b.cls, got.b.conf,
					got.line, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic [pco_pkg::COORD_BITS-1:0] box_x = '0, box_y = '0, box_w = '0, box_h = '0;
	logic [pco_pkg::CLASS_BITS-1:0] char_class = '0;
	logic [pco_pkg::CONF_BITS-1:0]  confidence = '0;
	logic last_box = 1'b0;
	logic out_valid, out_stall = 1'b0;
	logic [pco_pkg::COORD_BITS-1:0] out_x, out_y, out_w, out_h;
	logic [pco_pkg::CLASS_BITS-1:0] out_class;
	logic [pco_pkg::CONF_BITS-1:0]  out_confidence;
	logic second_line, last_char;

	plate_character_orderer u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	plate_scoreboard sb = new();
	// idle odds in percent, changed between phases
	int  send_idle = 13, recv_idle = 57;
	bit  hold_recv = 1'b0;
	int  quiet = 0;
	int  plates = 0, boxes = 0;

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		ordered_char_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.b.x = out_x; got.b.y = out_y; got.b.w = out_w; got.b.h = out_h;
			got.b.cls = out_class; got.b.conf = out_confidence;
			got.line = second_line; got.last = last_char;
			sb.check_char(got);
		end
		out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("plate_character_orderer test failed");
			$finish;
		end
	end

	// offer one box and hold it until it is accepted; valid stays high afterwards
	task automatic send_box(char_box_t b, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		box_x <= b.x; box_y <= b.y; box_w <= b.w; box_h <= b.h;
		char_class <= b.cls; confidence <= b.conf; last_box <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_box(b, last);
		boxes++;
		if (last) plates++;
	endtask

	function automatic char_box_t rand_box();
		char_box_t b;
		b.x = pco_pkg::COORD_BITS'($urandom); b.y = pco_pkg::COORD_BITS'($urandom);
		b.w = pco_pkg::COORD_BITS'($urandom); b.h = pco_pkg::COORD_BITS'($urandom);
		b.cls = pco_pkg::CLASS_BITS'($urandom); b.conf = pco_pkg::CONF_BITS'($urandom);
		return b;
	endfunction

	// well-formed plate: one or two rows of spaced characters, some close pairs
	task automatic send_plate(int cnt, bit two_rows);
		char_box_t b;
		int base_y = $urandom_range(3000);
		int cw = $urandom_range(10, 60);
		for (int i = 0; i < cnt; i++) begin
			b.w = pco_pkg::COORD_BITS'(cw + $urandom_range(4));
			b.h = pco_pkg::COORD_BITS'($urandom_range(20, 80));
			b.y = pco_pkg::COORD_BITS'(base_y + ((two_rows && i % 2) ? 100 : 0)
				+ $urandom_range(3));
			b.x = pco_pkg::COORD_BITS'(100 + (i / (two_rows ? 2 : 1)) * (cw + 5)
				+ $urandom_range(2));
			if ($urandom_range(7) == 0) b.x = pco_pkg::COORD_BITS'(100 + $urandom_range(3));
			b.cls = pco_pkg::CLASS_BITS'($urandom);
			b.conf = ($urandom_range(5) == 0) ? 16'h8000 : pco_pkg::CONF_BITS'($urandom);
			send_box(b, i == cnt - 1);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		char_box_t b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single box, extremes, ties, overflow of the store
		b = '{x: '1, y: '1, w: '1, h: '1, cls: '1, conf: '1};
		send_box(b, 1'b1);
		b = '{x: '0, y: '0, w: '0, h: '0, cls: '0, conf: '0};
		send_box(b, 1'b1);
		// two equal boxes: merge keeps the right one on a tie
		b = '{x: 12'd5, y: 12'd5, w: 12'd100, h: 12'd10, cls: 6'd1, conf: 16'd100};
		send_box(b, 1'b0);
		b.cls = 6'd2;
		send_box(b, 1'b1);
		// twelve boxes, two probabilities: on a tie the earliest lowest one is dropped
		for (int i = 0; i < 12; i++) begin
			b = '{x: 12'(400 - 30 * i), y: 12'(i % 2 ? 900 : 10), w: 12'd8, h: 12'd4,
				cls: 6'(i), conf: 16'(i < 6 ? 7 : 3)};
			send_box(b, i == 11);
		end
		// last box with lower probability than all kept is dropped
		for (int i = 0; i < 11; i++) begin
			b = rand_box();
			b.conf = (i == 10) ? 16'h0000 : 16'hFFFF;
			send_box(b, i == 10);
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 13 : (ph == 1) ? 57 : 0;
			recv_idle = (ph == 0) ? 57 : (ph == 1) ? 13 : 0;
			while (boxes < 50 + 70 * (ph + 1)) begin
				case ($urandom_range(9))
					0: send_box(rand_box(), $urandom_range(3) == 0);
					1: send_plate($urandom_range(1, 14), 1'b1);
					default: send_plate($urandom_range(2, 12), $urandom_range(1) == 1);
				endcase
			end
			// long receiver hold-off so the block backs up onto its input
			if (ph == 1) begin
				fork
					begin
						hold_recv = 1'b1;
						repeat (400) @(posedge clk);
						hold_recv = 1'b0;
					end
					begin
						send_plate(10, 1'b0);
						send_plate(6, 1'b1);
						in_valid <= 1'b0;
					end
				join
			end else begin
				in_valid <= 1'b0;
			end
			wait_drained();
		end
		// finish any partial plate
		b = rand_box();
		send_box(b, 1'b1);
		in_valid <= 1'b0;
		wait_drained();

		$display("covered %0d boxes in %0d plates, %0d ordered characters checked",
			boxes, plates, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("plate_character_orderer test passed");
		else
			$display("plate_character_orderer test failed");
		$finish;
	end
endmodule
